// File: src/unicycle_euler_integrator_macros.svh
// assertion helpers shared by the block's checking code
`ifndef UNICYCLE_EULER_INTEGRATOR_MACROS_SVH
`define UNICYCLE_EULER_INTEGRATOR_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define UEI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define UEI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/uei_pkg.sv
package uei_pkg;

    // sizing of the integrator
    localparam int SUBSTEPS         = 100;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);

    // field widths
    localparam int POS_W  = 48;   // Q16.32 position accumulator
    localparam int HEAD_W = 40;   // Q16.24 binary angle accumulator
    localparam int DT_W   = 24;   // step time, Q8.16
    localparam int TR_W   = 24;   // turn rate, Q16.8
    localparam int TRIG_W = 18;   // table entry, signed Q.16 including +-1.0
    localparam int MAG_W  = 17;   // magnitude of a table entry

    // step time split as q * SUBSTEPS + r
    localparam int R_W = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;
    localparam int Q_W = DT_W;

    // reciprocal of SUBSTEPS for 24-bit dividends
    localparam int RQ_S = DT_W + R_W + 1;
    localparam int RQ_W = DT_W + 3;
    localparam logic [RQ_W-1:0] RQ_M =
        RQ_W'(((64'd1 << RQ_S) + 64'(SUBSTEPS) - 64'd1) / 64'(SUBSTEPS));

    // reciprocal for the remainder part of a position increment
    localparam int RP_N = MAG_W + R_W;
    localparam int RP_S = RP_N + R_W + 1;
    localparam int RP_W = RP_N + 3;
    localparam logic [RP_W-1:0] RP_M =
        RP_W'(((64'd1 << RP_S) + 64'(SUBSTEPS) - 64'd1) / 64'(SUBSTEPS));

    // reciprocal for the remainder-by-remainder part of the heading increment
    localparam int RB_N = 2 * R_W;
    localparam int RB_S = RB_N + R_W + 1;
    localparam int RB_W = RB_N + 3;
    localparam logic [RB_W-1:0] RB_M =
        RB_W'(((64'd1 << RB_S) + 64'(SUBSTEPS) - 64'd1) / 64'(SUBSTEPS));

    // reset value of the step time register and its split
    localparam logic [DT_W-1:0] RESET_DT = DT_W'(65536);
    localparam logic [Q_W-1:0]  RESET_Q  = Q_W'(65536 / SUBSTEPS);
    localparam logic [R_W-1:0]  RESET_R  = R_W'(65536 % SUBSTEPS);

    // quarter wave series constants
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // pose travelling down the chain
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [HEAD_W-1:0]       head;
        logic [HEAD_W-1:0]       dth;
        logic                    sat;
    } pose_t;

    // step time split shared by the front end and the cells
    typedef struct packed {
        logic [Q_W-1:0] q;
        logic [R_W-1:0] r;
    } scale_t;

    typedef logic signed [TRIG_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

    // sine over the first quarter wave, argument in Q30 radians, result Q.16
    function automatic logic signed [TRIG_W-1:0] quarter_sine(input logic [63:0] x);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = x;
        sum  = $signed(x);
        for (int n = 0; n < 6; n++)
        begin
            term = ((((term * x) >> 30) * x) >> 30) / TAYLOR_DIV[n];
            if (n[0] == 1'b0)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        return TRIG_W'((sum + 64'sd8192) >>> 14);
    endfunction

    // full turn sine table
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t               rom;
        logic [63:0]             q;
        logic [63:0]             quad;
        logic [63:0]             rem;
        logic [63:0]             r;
        logic signed [TRIG_W-1:0] v;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            q    = 64'(i) * 64'd4;
            quad = q / SINE_TABLE_DEPTH;
            rem  = q % SINE_TABLE_DEPTH;
            r    = quad[0] ? (64'(SINE_TABLE_DEPTH) - rem) : rem;
            v    = quarter_sine((r * HALF_PI_Q30) / SINE_TABLE_DEPTH);
            rom[i] = quad[1] ? -v : v;
        end
        return rom;
    endfunction

endpackage

// File: src/uei_rate_scale.sv
module uei_rate_scale (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     valid_in,
    input  uei_pkg::pose_t           pose_in,
    input  logic [uei_pkg::TR_W-1:0] turn_rate,
    input  uei_pkg::scale_t          scale,
    output logic                     valid_out,
    output uei_pkg::pose_t           pose_out
);

    localparam int TR_W  = uei_pkg::TR_W;
    localparam int R_W   = uei_pkg::R_W;
    localparam int Q_W   = uei_pkg::Q_W;
    localparam int P_W   = TR_W + Q_W;
    localparam int T1_W  = TR_W + R_W;
    localparam int SUM_W = P_W + 1;

    logic [4:0] valid_reg;

    uei_pkg::pose_t f1_pose_reg, f2_pose_reg, f3_pose_reg, f4_pose_reg, f5_pose_reg;
    logic f1_neg_reg, f2_neg_reg, f3_neg_reg, f4_neg_reg;

    logic [TR_W-1:0]     f1_a_reg;
    logic [TR_W-1:0]     f1_aq_reg, f2_aq_reg;
    logic [P_W-1:0]      f1_p_reg, f2_p_reg, f3_p_reg;
    logic [R_W-1:0]      f2_ar_reg;
    logic [T1_W-1:0]     f3_t1_reg;
    logic [2*R_W-1:0]    f3_t2_reg;
    logic [SUM_W-1:0]    f4_s_reg;
    logic [R_W-1:0]      f4_t2q_reg;

    logic                turn_neg;
    logic [TR_W-1:0]     turn_mag;
    logic [TR_W-1:0]     aq_next;
    logic [P_W-1:0]      p_next;
    logic [R_W-1:0]      ar_next;
    logic [R_W-1:0]      t2q_next;
    logic [SUM_W-1:0]    mag;
    uei_pkg::pose_t      f5_pose_next;

    // magnitude of the turn rate and the quotient by the substep count
    assign turn_neg = turn_rate[TR_W-1];
    assign turn_mag = turn_neg ? TR_W'(-turn_rate) : turn_rate;
    assign aq_next  = TR_W'(((TR_W + uei_pkg::RQ_W)'(turn_mag)
                      * (TR_W + uei_pkg::RQ_W)'(uei_pkg::RQ_M)) >> uei_pkg::RQ_S);
    assign p_next   = P_W'(turn_mag) * P_W'(scale.q);

    // remainder of the turn rate by the substep count
    assign ar_next  = R_W'(f1_a_reg - TR_W'(f1_aq_reg * TR_W'(uei_pkg::SUBSTEPS)));

    // quotient of the small remainder product
    assign t2q_next = R_W'(((2*R_W + uei_pkg::RB_W)'(f3_t2_reg)
                      * (2*R_W + uei_pkg::RB_W)'(uei_pkg::RB_M)) >> uei_pkg::RB_S);

    // signed per-substep heading increment
    assign mag = f4_s_reg + SUM_W'(f4_t2q_reg);
    always_comb
    begin
        f5_pose_next     = f4_pose_reg;
        f5_pose_next.dth = f4_neg_reg ? uei_pkg::HEAD_W'(-mag) : uei_pkg::HEAD_W'(mag);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[3:0], valid_in};
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_pose_reg <= pose_in;
            f1_neg_reg  <= turn_neg;
            f1_a_reg    <= turn_mag;
            f1_aq_reg   <= aq_next;
            f1_p_reg    <= p_next;

            f2_pose_reg <= f1_pose_reg;
            f2_neg_reg  <= f1_neg_reg;
            f2_aq_reg   <= f1_aq_reg;
            f2_p_reg    <= f1_p_reg;
            f2_ar_reg   <= ar_next;

            f3_pose_reg <= f2_pose_reg;
            f3_neg_reg  <= f2_neg_reg;
            f3_p_reg    <= f2_p_reg;
            f3_t1_reg   <= T1_W'(f2_aq_reg) * T1_W'(scale.r);
            f3_t2_reg   <= (2*R_W)'(f2_ar_reg) * (2*R_W)'(scale.r);

            f4_pose_reg <= f3_pose_reg;
            f4_neg_reg  <= f3_neg_reg;
            f4_s_reg    <= SUM_W'(f3_p_reg) + SUM_W'(f3_t1_reg);
            f4_t2q_reg  <= t2q_next;

            f5_pose_reg <= f5_pose_next;
        end
    end

    assign valid_out = valid_reg[4];
    assign pose_out  = f5_pose_reg;

endmodule

// File: src/uei_cell.sv
module uei_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  uei_pkg::pose_t  pose_in,
    input  uei_pkg::scale_t scale,
    output logic            valid_out,
    output uei_pkg::pose_t  pose_out
);

    localparam int POS_W  = uei_pkg::POS_W;
    localparam int TRIG_W = uei_pkg::TRIG_W;
    localparam int MAG_W  = uei_pkg::MAG_W;
    localparam int IDX_W  = uei_pkg::IDX_W;
    localparam int HI_W   = MAG_W + uei_pkg::Q_W;
    localparam int LO_W   = uei_pkg::RP_N;
    localparam int LP_W   = LO_W + uei_pkg::RP_W;
    localparam int INC_W  = HI_W + 1;

    localparam uei_pkg::sine_rom_t SINE_MEM = uei_pkg::build_sine_rom();

    // table address of a 16-bit binary angle
    function automatic logic [IDX_W-1:0] rom_index(input logic [15:0] ang);
        logic [16+IDX_W-1:0] prod;
        prod = (16+IDX_W)'(ang) * (16+IDX_W)'(uei_pkg::SINE_TABLE_DEPTH);
        return prod[16 +: IDX_W];
    endfunction

    // saturate a grown position sum
    function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [POS_W:0] v);
        if (v[POS_W] != v[POS_W-1])
            return v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        return v[POS_W-1:0];
    endfunction

    logic [3:0] valid_reg;

    uei_pkg::pose_t a_pose_reg, b_pose_reg, c_pose_reg, d_pose_reg;
    uei_pkg::pose_t a_pose_next, d_pose_next;

    logic signed [TRIG_W-1:0] a_cos_reg, a_sin_reg;
    logic                     b_cos_neg_reg, b_sin_neg_reg;
    logic [HI_W-1:0]          b_cos_hi_reg, b_sin_hi_reg;
    logic [LO_W-1:0]          b_cos_lo_reg, b_sin_lo_reg;
    logic signed [INC_W:0]    c_cos_inc_reg, c_sin_inc_reg;

    logic [15:0]              ang_sin;
    logic [15:0]              ang_cos;
    logic                     cos_neg, sin_neg;
    logic [MAG_W-1:0]         cos_mag, sin_mag;
    logic [MAG_W-1:0]         cos_t, sin_t;
    logic [INC_W-1:0]         cos_sum, sin_sum;
    logic signed [POS_W:0]    x_sum, y_sum;
    logic                     x_clip, y_clip;

    // heading for this substep and the advanced heading for the next cell
    assign ang_sin = pose_in.head[uei_pkg::HEAD_W-1 -: 16];
    assign ang_cos = ang_sin + 16'd16384;
    always_comb
    begin
        a_pose_next      = pose_in;
        a_pose_next.head = pose_in.head + pose_in.dth;
    end

    // magnitude of the looked-up cosine and sine
    assign cos_neg = a_cos_reg[TRIG_W-1];
    assign sin_neg = a_sin_reg[TRIG_W-1];
    assign cos_mag = cos_neg ? MAG_W'(-a_cos_reg) : MAG_W'(a_cos_reg);
    assign sin_mag = sin_neg ? MAG_W'(-a_sin_reg) : MAG_W'(a_sin_reg);

    // quotient of the remainder product, then whole increment magnitude
    assign cos_t   = MAG_W'((LP_W'(b_cos_lo_reg) * LP_W'(uei_pkg::RP_M)) >> uei_pkg::RP_S);
    assign sin_t   = MAG_W'((LP_W'(b_sin_lo_reg) * LP_W'(uei_pkg::RP_M)) >> uei_pkg::RP_S);
    assign cos_sum = INC_W'(b_cos_hi_reg) + INC_W'(cos_t);
    assign sin_sum = INC_W'(b_sin_hi_reg) + INC_W'(sin_t);

    // position update with saturation
    assign x_sum  = (POS_W+1)'(c_pose_reg.x) + (POS_W+1)'(c_cos_inc_reg);
    assign y_sum  = (POS_W+1)'(c_pose_reg.y) + (POS_W+1)'(c_sin_inc_reg);
    assign x_clip = x_sum[POS_W] != x_sum[POS_W-1];
    assign y_clip = y_sum[POS_W] != y_sum[POS_W-1];
    always_comb
    begin
        d_pose_next     = c_pose_reg;
        d_pose_next.x   = clamp_pos(x_sum);
        d_pose_next.y   = clamp_pos(y_sum);
        d_pose_next.sat = c_pose_reg.sat | x_clip | y_clip;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], valid_in};
    end

    // table read, products, increments, accumulate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_cos_reg     <= SINE_MEM[rom_index(ang_cos)];
            a_sin_reg     <= SINE_MEM[rom_index(ang_sin)];
            a_pose_reg    <= a_pose_next;

            b_cos_neg_reg <= cos_neg;
            b_sin_neg_reg <= sin_neg;
            b_cos_hi_reg  <= HI_W'(cos_mag) * HI_W'(scale.q);
            b_sin_hi_reg  <= HI_W'(sin_mag) * HI_W'(scale.q);
            b_cos_lo_reg  <= LO_W'(cos_mag) * LO_W'(scale.r);
            b_sin_lo_reg  <= LO_W'(sin_mag) * LO_W'(scale.r);
            b_pose_reg    <= a_pose_reg;

            c_cos_inc_reg <= b_cos_neg_reg ? -$signed({1'b0, cos_sum}) : $signed({1'b0, cos_sum});
            c_sin_inc_reg <= b_sin_neg_reg ? -$signed({1'b0, sin_sum}) : $signed({1'b0, sin_sum});
            c_pose_reg    <= b_pose_reg;

            d_pose_reg    <= d_pose_next;
        end
    end

    assign valid_out = valid_reg[3];
    assign pose_out  = d_pose_reg;

endmodule

// File: src/unicycle_euler_integrator.sv
// Unicycle pose integrator, unit speed, forward Euler over SUBSTEPS substeps.
// Input stream (s_axis): one transaction per pose and turn rate. Output stream
// (m_axis): one transaction per input, in the same order, with the pose after
// one step of step_time seconds and a flag set if a position sum was clipped.
// Configuration: cfg_wr_en with cfg_wr_data writes step_time (unsigned Q8.16)
// on the rising edge; it is meant to change only while no transaction is in
// flight.
// Throughput: one transaction per cycle while the receiver does not stall.
// A result passes through an input register, a five-stage front end that
// scales the turn rate, and the chain of substep cells, each a four-stage pipe
// (table read, products, increment, saturating accumulate), then the output
// register before it shows on m_axis.
// Reset clears every valid bit and returns step_time to 1.0 s.
// When the receiver stalls with a result waiting, the whole pipe holds and
// s_axis_tready drops in the same cycle; a new transaction is taken in any
// cycle where the output register is empty or is being read.
`include "unicycle_euler_integrator_macros.svh"

module unicycle_euler_integrator (
    input  logic         clk,
    input  logic         rst_n,
    // step_time
    input  logic         cfg_wr_en,
    input  logic [23:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_x, start_y, start_heading, turn_rate
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // end_x, end_y, end_heading
    output logic [79:0]  m_axis_tdata,
    // saturated
    output logic         m_axis_tuser
);

    localparam int SUBSTEPS = uei_pkg::SUBSTEPS;
    localparam int DT_W     = uei_pkg::DT_W;
    localparam int Q_W      = uei_pkg::Q_W;
    localparam int R_W      = uei_pkg::R_W;
    localparam int POS_W    = uei_pkg::POS_W;
    localparam int HEAD_W   = uei_pkg::HEAD_W;

    logic [DT_W-1:0]  step_time_reg;
    logic [Q_W-1:0]   scale_q_reg;
    logic [R_W-1:0]   scale_r_reg;
    logic [DT_W-1:0]  rem_full;
    logic [Q_W-1:0]   scale_q_next;
    uei_pkg::scale_t  scale;

    logic                in_valid_reg;
    uei_pkg::pose_t      in_pose_reg;
    logic [23:0]         in_rate_reg;
    uei_pkg::pose_t      in_pose_next;

    logic                adv;
    logic [SUBSTEPS:0]   chain_valid;
    uei_pkg::pose_t      chain_pose [SUBSTEPS+1];

    logic                out_valid_reg;
    logic [79:0]         out_data_reg;
    logic                out_sat_reg;

    // step time register, split into quotient and remainder by the substep count
    assign scale_q_next = Q_W'(((DT_W + uei_pkg::RQ_W)'(cfg_wr_data)
                          * (DT_W + uei_pkg::RQ_W)'(uei_pkg::RQ_M)) >> uei_pkg::RQ_S);
    assign rem_full     = step_time_reg - DT_W'(scale_q_reg * DT_W'(SUBSTEPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= uei_pkg::RESET_DT;
            scale_q_reg   <= uei_pkg::RESET_Q;
            scale_r_reg   <= uei_pkg::RESET_R;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                step_time_reg <= cfg_wr_data;
                scale_q_reg   <= scale_q_next;
            end
            scale_r_reg <= R_W'(rem_full);
        end
    end

    assign scale.q = scale_q_reg;
    assign scale.r = scale_r_reg;

    // pipe advances whenever the output register can take a result
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // input transaction into accumulator formats
    always_comb
    begin
        in_pose_next.x    = $signed({s_axis_tdata[31:0], 16'b0});
        in_pose_next.y    = $signed({s_axis_tdata[63:32], 16'b0});
        in_pose_next.head = {s_axis_tdata[79:64], 24'b0};
        in_pose_next.dth  = '0;
        in_pose_next.sat  = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (adv)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_pose_reg <= in_pose_next;
            in_rate_reg <= s_axis_tdata[103:80];
        end
    end

    // heading increment per substep
    uei_rate_scale u_rate_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (in_valid_reg),
        .pose_in   (in_pose_reg),
        .turn_rate (in_rate_reg),
        .scale     (scale),
        .valid_out (chain_valid[0]),
        .pose_out  (chain_pose[0])
    );

    // one cell per substep
    for (genvar k = 0; k < SUBSTEPS; k++)
    begin : g_cell
        uei_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (chain_valid[k]),
            .pose_in   (chain_pose[k]),
            .scale     (scale),
            .valid_out (chain_valid[k+1]),
            .pose_out  (chain_pose[k+1])
        );
    end

    // output register, positions rounded toward minus infinity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= chain_valid[SUBSTEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {chain_pose[SUBSTEPS].head[HEAD_W-1 -: 16],
                             chain_pose[SUBSTEPS].y[POS_W-1:16],
                             chain_pose[SUBSTEPS].x[POS_W-1:16]};
            out_sat_reg  <= chain_pose[SUBSTEPS].sat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

    // checks
    `UEI_ASSERT_NOW(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")
    `UEI_ASSERT_NOW(a_step_split, 1'b1, rem_full < DT_W'(SUBSTEPS), "step time split has a bad remainder")
    `UEI_ASSERT_NOW(a_result_from_chain, $rose(m_axis_tvalid), $past(chain_valid[SUBSTEPS]), "result without a finished pose")
    `UEI_ASSERT_NEXT(a_accept_captured, s_axis_tvalid && s_axis_tready, in_valid_reg, "accepted transaction not captured")

endmodule
